>>> design/pca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pca_pkg
// Shared widths, register indexes and operation codes of the pixel color
// adjust block.
// ----------------------------------------------------------------------------
package pca_pkg;

    // channel and port widths
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_OPERATION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESAT_LVL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_OFS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_LVL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST   = 3'd4;

    // operation codes
    localparam logic [2:0] OP_DESAT    = 3'd0;
    localparam logic [2:0] OP_NEGATIVE = 3'd1;
    localparam logic [2:0] OP_BRIGHT   = 3'd2;
    localparam logic [2:0] OP_SAT      = 3'd3;
    localparam logic [2:0] OP_CONTRAST = 3'd4;

    // reset value of the contrast register (unity contrast)
    localparam logic [8:0] CONTRAST_RESET = 9'd100;

    // Q8 luma weights
    localparam logic [7:0] LUMA_R = 8'd77;
    localparam logic [7:0] LUMA_G = 8'd150;
    localparam logic [7:0] LUMA_B = 8'd29;

    // floor(x/3) = (x*683) >> 11, exact for x below 2048
    localparam logic [9:0] AVG_RECIP = 10'd683;

    // floor(m/25) = (m*5243) >> 17, exact for m below 43690
    localparam logic [12:0] CT_RECIP = 13'd5243;

    // contrast numerator at which the result reaches full scale (255*200)
    localparam logic signed [19:0] CT_FULL   = 20'sd51000;
    localparam logic signed [19:0] CT_OFFSET = 20'sd25500;

endpackage : pca_pkg
`default_nettype wire

>>> design/pixel_color_adjust.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_color_adjust
// Per-pixel RGB adjustment: desaturate, negative, brightness, saturation
// and contrast, selected by the operation register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with red_in, green_in, blue_in; a
//   pixel transfers on a clock edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with red_out, green_out, blue_out.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register
//   per edge; write only while no pixel is in flight.
//   From input transfer to out_valid a pixel passes four registers: sums and
//   luma, average / luma difference / contrast product, the multiplies, and
//   the final select and clamp in the output register.
//   Throughput is one pixel per clock while out_stall is low, set by the
//   four-stage pipeline; each stage holds only while the stage after it is
//   full and stalled, so bubbles close up under a stalled receiver.
//   When out_stall is held, the output pixel stays put and the pipeline
//   fills; in_stall rises once all four stages hold a pixel.
//   Reset empties the pipeline and loads the registers with operation
//   desaturate, levels and offsets zero and contrast 100 percent.
// ----------------------------------------------------------------------------
module pixel_color_adjust
    import pca_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration port
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input pixel channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [PIX_W-1:0]      red_in,
    input  wire logic [PIX_W-1:0]      green_in,
    input  wire logic [PIX_W-1:0]      blue_in,
    // output pixel channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [PIX_W-1:0]           red_out,
    output logic [PIX_W-1:0]           green_out,
    output logic [PIX_W-1:0]           blue_out
);

    // configuration registers
    logic [2:0]        operation_reg;
    logic [8:0]        desat_level_reg;
    logic signed [8:0] bright_offset_reg;
    logic signed [9:0] sat_level_reg;
    logic [8:0]        contrast_reg;

    // pipeline valid bits and stage enables
    logic valid_a_reg, valid_b_reg, valid_c_reg, out_valid_reg;
    logic ready_a, ready_b, ready_c, ready_d;

    // stage A: pixel, channel sum, luma
    logic [PIX_W-1:0]         pix_a_reg [3];
    logic [9:0]               sum_a_reg;
    logic [15:0]              luma_a_reg;
    logic [9:0]               sum_a_next;
    logic [15:0]              luma_a_next;

    // stage B: pixel, average, luma difference, contrast numerator
    logic [PIX_W-1:0]         pix_b_reg   [3];
    logic [PIX_W-1:0]         avg_b_reg;
    logic [15:0]              luma_b_reg;
    logic signed [17:0]       ydiff_b_reg [3];
    logic signed [19:0]       cnum_b_reg  [3];
    logic [PIX_W-1:0]         avg_b_next;
    logic signed [17:0]       ydiff_b_next [3];
    logic signed [19:0]       cnum_b_next  [3];

    // stage C: products and contrast range flags
    logic [PIX_W-1:0]         pix_c_reg    [3];
    logic [15:0]              luma_c_reg;
    logic [15:0]              dpix_c_reg   [3];
    logic [15:0]              davg_c_reg   [3];
    logic signed [27:0]       satp_c_reg   [3];
    logic [25:0]              cprod_c_reg  [3];
    logic                     cneg_c_reg   [3];
    logic                     cfull_c_reg  [3];
    logic [15:0]              dpix_c_next  [3];
    logic [15:0]              davg_c_next  [3];
    logic signed [27:0]       satp_c_next  [3];
    logic [25:0]              cprod_c_next [3];
    logic                     cneg_c_next  [3];
    logic                     cfull_c_next [3];

    // output register
    logic [PIX_W-1:0]         pix_out_reg  [3];
    logic [PIX_W-1:0]         pix_out_next [3];

    // clamped levels
    logic [8:0]  desat_lvl;
    logic [8:0]  desat_inv;
    logic [10:0] sat_gain;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operation_reg     <= OP_DESAT;
            desat_level_reg   <= '0;
            bright_offset_reg <= '0;
            sat_level_reg     <= '0;
            contrast_reg      <= CONTRAST_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_OPERATION:  operation_reg     <= cfg_data[2:0];
                REG_DESAT_LVL:  desat_level_reg   <= cfg_data[8:0];
                REG_BRIGHT_OFS: bright_offset_reg <= $signed(cfg_data[8:0]);
                REG_SAT_LVL:    sat_level_reg     <= $signed(cfg_data[9:0]);
                REG_CONTRAST:   contrast_reg      <= cfg_data[8:0];
                default:        ;
            endcase
        end
    end

    // level clamps: desaturate to 0..256, saturation gain 256+s to 0..512
    always_comb
    begin
        desat_lvl = (desat_level_reg > 9'd256) ? 9'd256 : desat_level_reg;
        desat_inv = 9'd256 - desat_lvl;
        if (sat_level_reg < -10'sd256)
            sat_gain = 11'd0;
        else if (sat_level_reg > 10'sd256)
            sat_gain = 11'd512;
        else
            sat_gain = 11'(11'sd256 + 11'(sat_level_reg));
    end

    // stage enables: a stage moves when it is empty or the next one moves
    assign ready_d  = !out_valid_reg || !out_stall;
    assign ready_c  = !valid_c_reg || ready_d;
    assign ready_b  = !valid_b_reg || ready_c;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_stall = !ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg   <= 1'b0;
            valid_b_reg   <= 1'b0;
            valid_c_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
                valid_a_reg <= in_valid;
            if (ready_b)
                valid_b_reg <= valid_a_reg;
            if (ready_c)
                valid_c_reg <= valid_b_reg;
            if (ready_d)
                out_valid_reg <= valid_c_reg;
        end
    end

    // stage A logic: channel sum and Q8 luma
    always_comb
    begin
        sum_a_next  = 10'(red_in) + 10'(green_in) + 10'(blue_in);
        luma_a_next = 16'(red_in) * 16'(LUMA_R) + 16'(green_in) * 16'(LUMA_G)
                    + 16'(blue_in) * 16'(LUMA_B);
    end

    // stage B logic: average, luma difference, contrast numerator
    always_comb
    begin
        logic [18:0]       avg_prod;
        logic signed [9:0] cdev;
        logic signed [9:0] cpct;
        avg_prod   = 19'(sum_a_reg) * 19'(AVG_RECIP);
        avg_b_next = avg_prod[18:11];
        for (int i = 0; i < 3; i++)
        begin
            ydiff_b_next[i] = $signed({2'b00, pix_a_reg[i], 8'h00})
                            - $signed({2'b00, luma_a_reg});
            cdev = $signed({1'b0, pix_a_reg[i], 1'b0}) - 10'sd255;
            cpct = $signed({1'b0, contrast_reg});
            cnum_b_next[i] = 20'(cdev) * 20'(cpct) + CT_OFFSET;
        end
    end

    // stage C logic: blend products, saturation product, contrast divide
    always_comb
    begin
        logic [12:0] cdiv;
        for (int i = 0; i < 3; i++)
        begin
            dpix_c_next[i]  = 16'(pix_b_reg[i]) * 16'(desat_inv);
            davg_c_next[i]  = 16'(avg_b_reg) * 16'(desat_lvl);
            satp_c_next[i]  = 28'(ydiff_b_reg[i]) * $signed({17'd0, sat_gain});
            cneg_c_next[i]  = cnum_b_reg[i][19];
            cfull_c_next[i] = cnum_b_reg[i] >= CT_FULL;
            // n/200 = (n/8)/25, valid when 0 <= n < 51000
            cdiv            = cnum_b_reg[i][15:3];
            cprod_c_next[i] = 26'(cdiv) * 26'(CT_RECIP);
        end
    end

    // output stage: per-operation finish and clamp
    always_comb
    begin
        logic [15:0]        dsum;
        logic signed [27:0] sat_q;
        logic signed [9:0]  bsum;
        for (int i = 0; i < 3; i++)
        begin
            dsum  = dpix_c_reg[i] + davg_c_reg[i];
            sat_q = satp_c_reg[i] + $signed({4'd0, luma_c_reg, 8'h00});
            bsum  = $signed({2'b00, pix_c_reg[i]}) + 10'(bright_offset_reg);
            case (operation_reg)
                OP_DESAT:
                    pix_out_next[i] = dsum[15:8];
                OP_NEGATIVE:
                    pix_out_next[i] = ~pix_c_reg[i];
                OP_BRIGHT:
                begin
                    if (bsum[9])
                        pix_out_next[i] = 8'd0;
                    else if (bsum[8])
                        pix_out_next[i] = 8'd255;
                    else
                        pix_out_next[i] = bsum[7:0];
                end
                OP_SAT:
                begin
                    if (sat_q[27])
                        pix_out_next[i] = 8'd0;
                    else if (sat_q[26:24] != 3'd0)
                        pix_out_next[i] = 8'd255;
                    else
                        pix_out_next[i] = sat_q[23:16];
                end
                OP_CONTRAST:
                begin
                    if (cneg_c_reg[i])
                        pix_out_next[i] = 8'd0;
                    else if (cfull_c_reg[i])
                        pix_out_next[i] = 8'd255;
                    else
                        pix_out_next[i] = cprod_c_reg[i][24:17];
                end
                default:
                    pix_out_next[i] = pix_c_reg[i];
            endcase
        end
    end

    // pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            pix_a_reg[0] <= red_in;
            pix_a_reg[1] <= green_in;
            pix_a_reg[2] <= blue_in;
            sum_a_reg    <= sum_a_next;
            luma_a_reg   <= luma_a_next;
        end
        if (ready_b && valid_a_reg)
        begin
            pix_b_reg   <= pix_a_reg;
            avg_b_reg   <= avg_b_next;
            luma_b_reg  <= luma_a_reg;
            ydiff_b_reg <= ydiff_b_next;
            cnum_b_reg  <= cnum_b_next;
        end
        if (ready_c && valid_b_reg)
        begin
            pix_c_reg   <= pix_b_reg;
            luma_c_reg  <= luma_b_reg;
            dpix_c_reg  <= dpix_c_next;
            davg_c_reg  <= davg_c_next;
            satp_c_reg  <= satp_c_next;
            cprod_c_reg <= cprod_c_next;
            cneg_c_reg  <= cneg_c_next;
            cfull_c_reg <= cfull_c_next;
        end
        if (ready_d && valid_c_reg)
            pix_out_reg <= pix_out_next;
    end

    // output ports
    assign out_valid = out_valid_reg;
    assign red_out   = pix_out_reg[0];
    assign green_out = pix_out_reg[1];
    assign blue_out  = pix_out_reg[2];

endmodule : pixel_color_adjust
`default_nettype wire

>>> design/pca_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pca_checker
// Port-level checks of the pixel color adjust block, bound to the top level.
// ----------------------------------------------------------------------------
module pca_checker
    import pca_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  cfg_write,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [PIX_W-1:0]      red_out,
    input wire logic [PIX_W-1:0]      green_out,
    input wire logic [PIX_W-1:0]      blue_out
);

    // a stalled output pixel holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out))
        else $error("output pixel changed while stalled");

    // the input side only stalls when the output is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled output");

    // a fresh output pixel follows an earlier input transfer
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 4))
        else $error("output appeared without a matching input transfer");

    // a configuration write never lands while the pipeline is full and stalled
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |-> !(out_valid && out_stall) || !in_stall)
        else $error("configuration written with a full pipeline");

endmodule : pca_checker

bind pixel_color_adjust pca_checker u_pca_checker (.*);
`default_nettype wire
